// File: rtl/clcd_pkg.sv
// Shared types, constants and command/status structs for the character LCD expander driver.
package clcd_pkg;

	localparam logic [1:0] REQ_CHAR  = 2'd0;
	localparam logic [1:0] REQ_CMD   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_INIT  = 2'd3;

	localparam logic REG_CPL = 1'b0;
	localparam logic REG_BL  = 1'b1;

	localparam logic [6:0] CPL_RESET            = 7'd16;
	localparam logic       BL_RESET             = 1'b1;
	localparam logic [6:0] SECOND_LINE_ADDR_DEF = 7'd64;

	localparam logic [7:0] LCD_CLEAR     = 8'h01;
	localparam logic [7:0] LCD_HOME      = 8'h02;
	localparam logic [7:0] LCD_ENTRY     = 8'h06;
	localparam logic [7:0] LCD_DISP_ON   = 8'h0D;
	localparam logic [7:0] LCD_FUNC_SET  = 8'h2C;
	localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
	localparam logic [7:0] RAW_BL_MASK   = 8'hF7;

	localparam int unsigned RAW_LEN = 8;

	typedef enum logic [2:0] {
		SRC_VALUE,
		SRC_HOME,
		SRC_ADDR,
		SRC_CLEAR,
		SRC_ADDR0,
		SRC_FSET,
		SRC_DON,
		SRC_ENTRY
	} src_t;

	typedef struct packed {
		logic       accept;
		logic       load;
		logic       raw;
		logic [2:0] raw_idx;
		src_t       src;
		logic       rs;
		logic [1:0] phase;
		logic       last;
	} ctl_cmd_t;

	typedef struct packed {
		logic wrap;
		logic out_free;
	} dp_stat_t;

	// Power-up wake sequence, sent as raw expander bytes.
	function automatic logic [7:0] init_raw(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd6:    b = 8'h2C;
			3'd7:    b = 8'h28;
			default: b = idx[0] ? 8'h38 : 8'h3C;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/clcd_datapath.sv
// Datapath: config registers, cursor state, byte/nibble formatting and output register.
module clcd_datapath import clcd_pkg::*; #(
	parameter logic [6:0] SECOND_LINE_ADDR = SECOND_LINE_ADDR_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   cmd,
	output dp_stat_t   stat,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	input  logic [7:0] value,
	input  logic [1:0] req_type,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [6:0] cpl_q;
	logic       bl_q;
	logic [6:0] col_q;
	logic       line_q;
	logic       wrap_q;
	logic [7:0] value_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic [7:0] next_col;
	logic       wrap_now;
	logic [7:0] cur_byte;
	logic [3:0] nib;
	logic [7:0] fmt_byte;
	logic [7:0] raw_byte;

	assign next_col = {1'b0, col_q} + 8'd1;
	assign wrap_now = next_col >= {1'b0, cpl_q};

	always_comb begin
		case (cmd.src)
			SRC_VALUE: cur_byte = value_q;
			SRC_HOME:  cur_byte = LCD_HOME;
			SRC_ADDR:  cur_byte = LCD_SET_DDRAM | {1'b0, (line_q ? SECOND_LINE_ADDR : 7'd0)};
			SRC_CLEAR: cur_byte = LCD_CLEAR;
			SRC_ADDR0: cur_byte = LCD_SET_DDRAM;
			SRC_FSET:  cur_byte = LCD_FUNC_SET;
			SRC_DON:   cur_byte = LCD_DISP_ON;
			SRC_ENTRY: cur_byte = LCD_ENTRY;
			default:   cur_byte = LCD_SET_DDRAM;
		endcase
	end

	// phase[1] picks the low nibble, phase[0] drops enable
	assign nib      = cmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
	assign fmt_byte = {nib, bl_q, ~cmd.phase[0], 1'b0, cmd.rs};
	assign raw_byte = (init_raw(cmd.raw_idx) & RAW_BL_MASK) | {4'b0000, bl_q, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_q  <= CPL_RESET;
			bl_q   <= BL_RESET;
			col_q  <= '0;
			line_q <= 1'b0;
			wrap_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_CPL) cpl_q <= cfg_data;
				else                      bl_q  <= cfg_data[0];
			end
			if (cmd.accept) begin
				case (req_type)
					REQ_CHAR: begin
						wrap_q <= wrap_now;
						if (wrap_now) begin
							col_q  <= '0;
							line_q <= ~line_q;
						end else begin
							col_q <= next_col[6:0];
						end
					end
					REQ_CMD: wrap_q <= 1'b0;
					default: begin
						wrap_q <= 1'b0;
						col_q  <= '0;
						line_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) value_q <= value;
		if (cmd.load) begin
			out_byte_q <= cmd.raw ? raw_byte : fmt_byte;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	assign stat.wrap     = wrap_q;
	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_byte_q;
	assign m_tlast       = out_last_q;

endmodule

// File: rtl/clcd_ctrl.sv
// Controller: sequences raw init bytes and the nibble transactions of each LCD byte.
module clcd_ctrl import clcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] req_type,
	input  dp_stat_t   stat,
	output ctl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RAW  = 3'b010,
		S_NIB  = 3'b100
	} state_t;

	state_t     state_q;
	logic [1:0] req_q;
	logic [2:0] raw_q;
	logic [2:0] step_q;
	logic [1:0] phase_q;

	src_t src;
	logic rs;
	logic last_step;
	logic accept;
	logic adv;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign adv      = stat.out_free;

	always_comb begin
		rs = 1'b0;
		case (req_q)
			REQ_CHAR: begin
				rs        = (step_q == 3'd0);
				src       = (step_q == 3'd0) ? SRC_VALUE :
				            (step_q == 3'd1) ? SRC_HOME : SRC_ADDR;
				last_step = stat.wrap ? (step_q == 3'd2) : (step_q == 3'd0);
			end
			REQ_CMD: begin
				src       = SRC_VALUE;
				last_step = 1'b1;
			end
			REQ_CLEAR: begin
				src       = (step_q == 3'd0) ? SRC_CLEAR : SRC_ADDR0;
				last_step = (step_q == 3'd1);
			end
			default: begin
				case (step_q)
					3'd0:    src = SRC_CLEAR;
					3'd1:    src = SRC_ADDR0;
					3'd2:    src = SRC_FSET;
					3'd3:    src = SRC_DON;
					default: src = SRC_ENTRY;
				endcase
				last_step = (step_q == 3'd4);
			end
		endcase
	end

	assign cmd.accept  = accept;
	assign cmd.load    = adv && (state_q == S_RAW || state_q == S_NIB);
	assign cmd.raw     = (state_q == S_RAW);
	assign cmd.raw_idx = raw_q;
	assign cmd.src     = src;
	assign cmd.rs      = rs;
	assign cmd.phase   = phase_q;
	assign cmd.last    = (state_q == S_NIB) && (phase_q == 2'd3) && last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= REQ_CHAR;
			raw_q   <= '0;
			step_q  <= '0;
			phase_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q   <= req_type;
						raw_q   <= '0;
						step_q  <= '0;
						phase_q <= '0;
						state_q <= (req_type == REQ_INIT) ? S_RAW : S_NIB;
					end
				end
				S_RAW: begin
					if (adv) begin
						raw_q <= raw_q + 3'd1;
						if (raw_q == 3'(RAW_LEN - 1)) state_q <= S_NIB;
					end
				end
				S_NIB: begin
					if (adv) begin
						phase_q <= phase_q + 2'd1;
						if (phase_q == 2'd3) begin
							step_q <= step_q + 3'd1;
							if (last_step) state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q != S_IDLE)
		else $error("output load while idle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted request did not start");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.last) |=> state_q == S_IDLE)
		else $error("last transaction did not end the request");

	a_raw_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RAW |-> (phase_q == 2'd0 && step_q == 3'd0))
		else $error("nibble counters moved during raw sequence");

endmodule

// File: rtl/char_lcd_nibble_expander_driver.sv
// Top level of the character LCD driver for a port expander in 4-bit mode.
// One request is taken per idle cycle; its expander bytes then leave at up to one
// transaction per cycle through a single output register, and no new request is taken
// until its last byte has been loaded: a character gives 4 bytes (12 when the line wraps),
// a raw command 4, a clear 8 and the init sequence 28. The output register and the
// downstream tready set the pace.
module char_lcd_nibble_expander_driver import clcd_pkg::*; #(
	parameter logic [6:0] SECOND_LINE_ADDR = SECOND_LINE_ADDR_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] value
	input  logic [1:0] s_tuser,   // [1:0] req_type
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] expander_byte
	output logic       m_tlast
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	clcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	clcd_datapath #(
		.SECOND_LINE_ADDR (SECOND_LINE_ADDR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.value     (s_tdata),
		.req_type  (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
